// ===== rtl/mcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants of the metronome click generator
// Holds the request kinds, register indexes, field widths, the configuration
// and per-frame control structs, and small helper functions.
// ----------------------------------------------------------------------------
package mcg_pkg;

	// Sound memory geometry and beat limits.
	localparam int SOUND_DEPTH  = 8192;
	localparam int ADDR_W       = 13;
	localparam int FRAME_W      = 14;
	localparam int MAX_BEATS    = 12;
	localparam int PATTERN_BITS = 12;
	localparam int SAMPLE_W     = 16;

	// Configuration register widths.
	localparam int SPB_W       = 17;
	localparam int BIM_W       = 4;
	localparam int LEN_W       = 14;
	localparam int CFG_DATA_W  = 17;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BEAT_PERIOD      = 3'd0,
		REG_BEATS_IN_MEASURE = 3'd1,
		REG_ACCENT_PATTERN   = 3'd2,
		REG_NORMAL_LENGTH    = 3'd3,
		REG_ACCENT_LENGTH    = 3'd4,
		REG_STEREO_FLAGS     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [SPB_W-1:0]        beat_period;
		logic [BIM_W-1:0]        beats_in_measure;
		logic [PATTERN_BITS-1:0] accent_pattern;
		logic [LEN_W-1:0]        normal_length;
		logic [LEN_W-1:0]        accent_length;
		logic [1:0]              stereo_flags;
	} cfg_t;

	// Control that travels with one frame from the timer to the mixer.
	typedef struct packed {
		logic             normal_on;
		logic             normal_stereo;
		logic             accent_on;
		logic             accent_stereo;
		logic             beat_start;
		logic [BIM_W-1:0] beat_number;
		logic             beat_accented;
		logic             is_running;
	} frame_ctrl_t;

	// Builds a lookup of v mod m for 4-bit v and m by counting, no divider.
	function automatic logic [1023:0] build_mod_lut();
		logic [1023:0] t;
		logic [3:0]    r;
		t = '0;
		for (int m = 1; m < 16; m++) begin
			r = 4'd0;
			for (int v = 0; v < 16; v++) begin
				t[(v * 16 + m) * 4 +: 4] = r;
				r = ((r + 4'd1) == 4'(m)) ? 4'd0 : r + 4'd1;
			end
		end
		return t;
	endfunction

	localparam logic [1023:0] MOD_LUT = build_mod_lut();

	function automatic logic [BIM_W-1:0] mod_wrap(input logic [3:0] v, input logic [3:0] m);
		return MOD_LUT[{v, m, 2'b00} +: 4];
	endfunction

	// Clamps a sound length to what the memory holds in mono or stereo layout.
	function automatic logic [FRAME_W-1:0] cap_length(input logic [LEN_W-1:0] len,
		input logic stereo);
		logic [FRAME_W-1:0] cap;
		cap = stereo ? FRAME_W'(SOUND_DEPTH / 2) : FRAME_W'(SOUND_DEPTH);
		return (len > cap) ? cap : len;
	endfunction

	// Saturates a 17-bit sum to a 16-bit sample.
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== rtl/mcg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_if: request and result channels of the metronome click generator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface mcg_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          kind;
	logic                                voice_select;
	logic [mcg_pkg::ADDR_W-1:0]          load_address;
	logic signed [mcg_pkg::SAMPLE_W-1:0] load_sample;

	modport source (output valid, kind, voice_select, load_address, load_sample,
		input ready);
	modport sink (input valid, kind, voice_select, load_address, load_sample,
		output ready);
endinterface

interface mcg_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [mcg_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [mcg_pkg::SAMPLE_W-1:0] right_sample;
	logic                                beat_start;
	logic [mcg_pkg::BIM_W-1:0]           beat_number;
	logic                                beat_accented;
	logic                                is_running;

	modport source (output valid, left_sample, right_sample, beat_start, beat_number,
		beat_accented, is_running, input ready);
	modport sink (input valid, left_sample, right_sample, beat_start, beat_number,
		beat_accented, is_running, output ready);
endinterface

// ===== rtl/mcg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_ram: generic RAM, one write port and two registered read ports
// Read data updates only when the read enable is high and holds otherwise.
// ----------------------------------------------------------------------------
module mcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read ports.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/mcg_beat_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_beat_timer: beat countdown, beat index and voice playback positions
// Updates on start, stop and, while running, tick requests; gives the sound
// memory read addresses and the control for the frame being produced.
// ----------------------------------------------------------------------------
module mcg_beat_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcg_pkg::cfg_t               cfg,
	input  logic                        tick_fire,
	input  logic                        start_fire,
	input  logic                        stop_fire,
	output mcg_pkg::frame_ctrl_t        ctrl,
	output logic [mcg_pkg::ADDR_W-1:0]  normal_addr_a,
	output logic [mcg_pkg::ADDR_W-1:0]  normal_addr_b,
	output logic [mcg_pkg::ADDR_W-1:0]  accent_addr_a,
	output logic [mcg_pkg::ADDR_W-1:0]  accent_addr_b
);

	logic                          running_q;
	logic [mcg_pkg::SPB_W-1:0]     countdown_q;
	logic [mcg_pkg::BIM_W-1:0]     position_q;
	logic                          normal_playing_q;
	logic [mcg_pkg::FRAME_W-1:0]   normal_frame_q;
	logic                          accent_playing_q;
	logic [mcg_pkg::FRAME_W-1:0]   accent_frame_q;

	logic                          beat_now;
	logic                          accented;
	logic [mcg_pkg::BIM_W-1:0]     bim_eff;
	logic [mcg_pkg::BIM_W-1:0]     position_next;
	logic [mcg_pkg::SPB_W-1:0]     countdown_next;
	logic                          normal_play0;
	logic                          accent_play0;
	logic [mcg_pkg::FRAME_W-1:0]   normal_frame0;
	logic [mcg_pkg::FRAME_W-1:0]   accent_frame0;
	logic [mcg_pkg::FRAME_W-1:0]   normal_len;
	logic [mcg_pkg::FRAME_W-1:0]   accent_len;
	logic [mcg_pkg::FRAME_W-1:0]   normal_frame_inc;
	logic [mcg_pkg::FRAME_W-1:0]   accent_frame_inc;
	logic                          normal_on;
	logic                          accent_on;

	// Beat decision and wrap of the beat index.
	always_comb begin
		beat_now = (countdown_q == '0);
		accented = (position_q < mcg_pkg::BIM_W'(mcg_pkg::PATTERN_BITS))
			&& cfg.accent_pattern[position_q];
		if (cfg.beats_in_measure == '0) begin
			bim_eff = mcg_pkg::BIM_W'(1);
		end else if (cfg.beats_in_measure > mcg_pkg::BIM_W'(mcg_pkg::MAX_BEATS)) begin
			bim_eff = mcg_pkg::BIM_W'(mcg_pkg::MAX_BEATS);
		end else begin
			bim_eff = cfg.beats_in_measure;
		end
		position_next  = mcg_pkg::mod_wrap(position_q + 4'd1, bim_eff);
		countdown_next = (cfg.beat_period == '0) ? '0
			: cfg.beat_period - mcg_pkg::SPB_W'(1);
	end

	// Voice restart on a beat, then one frame of playback per tick.
	always_comb begin
		normal_play0  = normal_playing_q;
		normal_frame0 = normal_frame_q;
		accent_play0  = accent_playing_q;
		accent_frame0 = accent_frame_q;
		if (beat_now && accented) begin
			accent_play0  = 1'b1;
			accent_frame0 = '0;
		end else if (beat_now) begin
			normal_play0  = 1'b1;
			normal_frame0 = '0;
		end
		normal_len       = mcg_pkg::cap_length(cfg.normal_length, cfg.stereo_flags[0]);
		accent_len       = mcg_pkg::cap_length(cfg.accent_length, cfg.stereo_flags[1]);
		normal_on        = normal_play0 && (normal_frame0 < normal_len);
		accent_on        = accent_play0 && (accent_frame0 < accent_len);
		normal_frame_inc = normal_frame0 + mcg_pkg::FRAME_W'(1);
		accent_frame_inc = accent_frame0 + mcg_pkg::FRAME_W'(1);
	end

	// Memory addresses; stereo words interleave left and right.
	always_comb begin
		if (cfg.stereo_flags[0]) begin
			normal_addr_a = {normal_frame0[mcg_pkg::ADDR_W-2:0], 1'b0};
		end else begin
			normal_addr_a = normal_frame0[mcg_pkg::ADDR_W-1:0];
		end
		normal_addr_b = {normal_frame0[mcg_pkg::ADDR_W-2:0], 1'b1};
		if (cfg.stereo_flags[1]) begin
			accent_addr_a = {accent_frame0[mcg_pkg::ADDR_W-2:0], 1'b0};
		end else begin
			accent_addr_a = accent_frame0[mcg_pkg::ADDR_W-1:0];
		end
		accent_addr_b = {accent_frame0[mcg_pkg::ADDR_W-2:0], 1'b1};
	end

	// Control for the frame; a stopped tick is silent with no beat.
	always_comb begin
		ctrl.normal_on     = running_q && normal_on;
		ctrl.normal_stereo = cfg.stereo_flags[0];
		ctrl.accent_on     = running_q && accent_on;
		ctrl.accent_stereo = cfg.stereo_flags[1];
		ctrl.beat_start    = running_q && beat_now;
		ctrl.beat_number   = (running_q && beat_now) ? position_q : '0;
		ctrl.beat_accented = running_q && beat_now && accented;
		ctrl.is_running    = running_q;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q        <= 1'b0;
			countdown_q      <= '0;
			position_q       <= '0;
			normal_playing_q <= 1'b0;
			normal_frame_q   <= '0;
			accent_playing_q <= 1'b0;
			accent_frame_q   <= '0;
		end else if (start_fire) begin
			running_q   <= 1'b1;
			countdown_q <= '0;
			position_q  <= '0;
		end else if (stop_fire) begin
			running_q <= 1'b0;
		end else if (tick_fire && running_q) begin
			if (beat_now) begin
				countdown_q <= countdown_next;
				position_q  <= position_next;
			end else begin
				countdown_q <= countdown_q - mcg_pkg::SPB_W'(1);
			end
			normal_playing_q <= normal_on && (normal_frame_inc < normal_len);
			normal_frame_q   <= normal_on ? normal_frame_inc : normal_frame0;
			accent_playing_q <= accent_on && (accent_frame_inc < accent_len);
			accent_frame_q   <= accent_on ? accent_frame_inc : accent_frame0;
		end
	end

endmodule

// ===== rtl/metronome_click_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metronome_click_generator_top: sample-accurate metronome click generator
//
// Requests arrive on req: a tick asks for one stereo frame, a load writes one
// word into the normal or accent sound memory, start and stop control the
// beat clock. Each tick gives exactly one result on rsp; load, start and stop
// give none. Registers are written through cfg_wr_en, cfg_index and cfg_data;
// the user is to write them only while the block is idle, and the block itself
// does not enforce this. One request is taken per cycle, back to back, while
// req.ready is high. A tick's result passes through the registered sound
// memory read, then the mix and saturation into the output register.
// When the receiver stalls, the output register holds its result and the
// memory read stage holds the next frame; req.ready drops only when both are
// full. Reset clears the beat state, the playback positions and the pipeline
// and restores the register defaults; sound memory contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module metronome_click_generator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	mcg_req_if.sink                          req,
	mcg_rsp_if.source                        rsp,
	input  logic                             cfg_wr_en,
	input  logic [mcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mcg_pkg::cfg_t                        cfg_q;
	mcg_pkg::frame_ctrl_t                 ctrl;
	mcg_pkg::frame_ctrl_t                 ctrl_s1;
	logic                                 valid_s1;
	logic                                 advance;
	logic                                 req_fire;
	logic                                 tick_fire;
	logic                                 start_fire;
	logic                                 stop_fire;
	logic                                 load_fire;
	logic [mcg_pkg::ADDR_W-1:0]           normal_addr_a;
	logic [mcg_pkg::ADDR_W-1:0]           normal_addr_b;
	logic [mcg_pkg::ADDR_W-1:0]           accent_addr_a;
	logic [mcg_pkg::ADDR_W-1:0]           accent_addr_b;
	logic [mcg_pkg::SAMPLE_W-1:0]         normal_rd_a;
	logic [mcg_pkg::SAMPLE_W-1:0]         normal_rd_b;
	logic [mcg_pkg::SAMPLE_W-1:0]         accent_rd_a;
	logic [mcg_pkg::SAMPLE_W-1:0]         accent_rd_b;
	logic signed [mcg_pkg::SAMPLE_W:0]    left_sum;
	logic signed [mcg_pkg::SAMPLE_W:0]    right_sum;
	logic signed [mcg_pkg::SAMPLE_W:0]    normal_left;
	logic signed [mcg_pkg::SAMPLE_W:0]    normal_right;
	logic signed [mcg_pkg::SAMPLE_W:0]    accent_left;
	logic signed [mcg_pkg::SAMPLE_W:0]    accent_right;
	logic                                 out_valid_q;
	logic signed [mcg_pkg::SAMPLE_W-1:0]  left_q;
	logic signed [mcg_pkg::SAMPLE_W-1:0]  right_q;
	logic                                 beat_start_q;
	logic [mcg_pkg::BIM_W-1:0]            beat_number_q;
	logic                                 beat_accented_q;
	logic                                 is_running_q;

	// Handshake and request decode.
	always_comb begin
		advance    = !out_valid_q || rsp.ready;
		req.ready  = !valid_s1 || advance;
		req_fire   = req.valid && req.ready;
		tick_fire  = req_fire && (mcg_pkg::kind_t'(req.kind) == mcg_pkg::KIND_TICK);
		load_fire  = req_fire && (mcg_pkg::kind_t'(req.kind) == mcg_pkg::KIND_LOAD);
		start_fire = req_fire && (mcg_pkg::kind_t'(req.kind) == mcg_pkg::KIND_START);
		stop_fire  = req_fire && (mcg_pkg::kind_t'(req.kind) == mcg_pkg::KIND_STOP);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_period      <= mcg_pkg::SPB_W'(24000);
			cfg_q.beats_in_measure <= mcg_pkg::BIM_W'(4);
			cfg_q.accent_pattern   <= mcg_pkg::PATTERN_BITS'(1);
			cfg_q.normal_length    <= '0;
			cfg_q.accent_length    <= '0;
			cfg_q.stereo_flags     <= '0;
		end else if (cfg_wr_en) begin
			case (mcg_pkg::reg_index_t'(cfg_index))
				mcg_pkg::REG_BEAT_PERIOD: begin
					cfg_q.beat_period <= cfg_data[mcg_pkg::SPB_W-1:0];
				end
				mcg_pkg::REG_BEATS_IN_MEASURE: begin
					cfg_q.beats_in_measure <= cfg_data[mcg_pkg::BIM_W-1:0];
				end
				mcg_pkg::REG_ACCENT_PATTERN: begin
					cfg_q.accent_pattern <= cfg_data[mcg_pkg::PATTERN_BITS-1:0];
				end
				mcg_pkg::REG_NORMAL_LENGTH: begin
					cfg_q.normal_length <= cfg_data[mcg_pkg::LEN_W-1:0];
				end
				mcg_pkg::REG_ACCENT_LENGTH: begin
					cfg_q.accent_length <= cfg_data[mcg_pkg::LEN_W-1:0];
				end
				mcg_pkg::REG_STEREO_FLAGS: begin
					cfg_q.stereo_flags <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Beat timing and playback positions.
	mcg_beat_timer u_timer (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.tick_fire     (tick_fire),
		.start_fire    (start_fire),
		.stop_fire     (stop_fire),
		.ctrl          (ctrl),
		.normal_addr_a (normal_addr_a),
		.normal_addr_b (normal_addr_b),
		.accent_addr_a (accent_addr_a),
		.accent_addr_b (accent_addr_b)
	);

	// Sound memories: loads write, ticks read.
	mcg_ram #(
		.WIDTH (mcg_pkg::SAMPLE_W),
		.DEPTH (mcg_pkg::SOUND_DEPTH)
	) u_normal_mem (
		.clk       (clk),
		.wr_en     (load_fire && !req.voice_select),
		.wr_addr   (req.load_address),
		.wr_data   (req.load_sample),
		.rd_en     (tick_fire),
		.rd_addr_a (normal_addr_a),
		.rd_addr_b (normal_addr_b),
		.rd_data_a (normal_rd_a),
		.rd_data_b (normal_rd_b)
	);

	mcg_ram #(
		.WIDTH (mcg_pkg::SAMPLE_W),
		.DEPTH (mcg_pkg::SOUND_DEPTH)
	) u_accent_mem (
		.clk       (clk),
		.wr_en     (load_fire && req.voice_select),
		.wr_addr   (req.load_address),
		.wr_data   (req.load_sample),
		.rd_en     (tick_fire),
		.rd_addr_a (accent_addr_a),
		.rd_addr_b (accent_addr_b),
		.rd_data_a (accent_rd_a),
		.rd_data_b (accent_rd_b)
	);

	// Memory read stage: the frame control waits for the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= tick_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			ctrl_s1 <= ctrl;
		end
	end

	// Mix both voices; a mono voice feeds both channels.
	always_comb begin
		normal_left  = '0;
		normal_right = '0;
		accent_left  = '0;
		accent_right = '0;
		if (ctrl_s1.normal_on) begin
			normal_left  = {normal_rd_a[mcg_pkg::SAMPLE_W-1], normal_rd_a};
			normal_right = ctrl_s1.normal_stereo
				? {normal_rd_b[mcg_pkg::SAMPLE_W-1], normal_rd_b}
				: {normal_rd_a[mcg_pkg::SAMPLE_W-1], normal_rd_a};
		end
		if (ctrl_s1.accent_on) begin
			accent_left  = {accent_rd_a[mcg_pkg::SAMPLE_W-1], accent_rd_a};
			accent_right = ctrl_s1.accent_stereo
				? {accent_rd_b[mcg_pkg::SAMPLE_W-1], accent_rd_b}
				: {accent_rd_a[mcg_pkg::SAMPLE_W-1], accent_rd_a};
		end
		left_sum  = normal_left + accent_left;
		right_sum = normal_right + accent_right;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			left_q          <= mcg_pkg::sat16(left_sum);
			right_q         <= mcg_pkg::sat16(right_sum);
			beat_start_q    <= ctrl_s1.beat_start;
			beat_number_q   <= ctrl_s1.beat_number;
			beat_accented_q <= ctrl_s1.beat_accented;
			is_running_q    <= ctrl_s1.is_running;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.left_sample   = left_q;
	assign rsp.right_sample  = right_q;
	assign rsp.beat_start    = beat_start_q;
	assign rsp.beat_number   = beat_number_q;
	assign rsp.beat_accented = beat_accented_q;
	assign rsp.is_running    = is_running_q;

endmodule
